// ===== rtl/cau_pkg.sv =====
// ============================================================================
// cau_pkg
// Shared types and codes for the complex arithmetic unit.
// ============================================================================
`default_nettype none

package cau_pkg;

  localparam int unsigned WORD_W = 32;  // Q-format word
  localparam int unsigned MAG_W  = 64;  // exact product / sum magnitude
  localparam int unsigned QUO_W  = 33;  // quotient bits kept by the divider

  // commands
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_MUL = 2'd1;
  localparam logic [1:0] CMD_DIV = 2'd2;
  localparam logic [1:0] CMD_MAG = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic        [1:0]        command;
    logic signed [WORD_W-1:0] a_re;
    logic signed [WORD_W-1:0] a_im;
    logic signed [WORD_W-1:0] b_re;
    logic signed [WORD_W-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] res_re;
    logic signed [WORD_W-1:0] res_im;
    logic        [1:0]        status;
  } cau_out_t;

endpackage

`default_nettype wire

// ===== rtl/complex_arithmetic_unit_core.sv =====
// ============================================================================
// complex_arithmetic_unit_core
// Pipelined complex ALU on signed fixed point: add, multiply, divide, |a|.
// ============================================================================
// Usage:
//   Input channel: an operand beat (command, a, b) is taken at each rising
//   edge where start is high and busy is low. busy is tied low, so a new
//   beat may be issued every cycle.
//   Output channel: done pulses for one cycle with result (res_re, res_im,
//   status). There is no backpressure: the receiver must take every beat.
//   Throughput: one beat per cycle, for every command.
//   What sets the depth: the 33-stage restoring divider (one quotient bit
//   per stage) behind four front stages (abs, multiply, sum, magnitude),
//   plus a select stage and the saturating output register.
//   The square-root pipe (32 stages) runs beside the divider.
//   Reset (rst, synchronous): clears all valid bits; beats in flight are
//   dropped and no strobe follows. Datapath registers are not reset.
//   Status: ok, saturated (either part clamped), or divide by zero
//   (both parts forced to zero).
// ============================================================================
`default_nettype none

module complex_arithmetic_unit_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cau_pkg::cau_in_t  operands,
  output logic              done,
  output cau_pkg::cau_out_t result
);
  import cau_pkg::*;

  localparam int unsigned DIV_LAT = QUO_W + 1;       // divider entry + bit stages
  localparam int unsigned LATENCY = 4 + DIV_LAT + 2; // front + divider + select/out
  localparam logic [MAG_W-1:0]  NEG_LIM  = 64'h0000_0000_8000_0000;
  localparam logic [MAG_W-1:0]  POS_LIM  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [WORD_W-1:0] MIN_WORD = 32'h8000_0000;
  localparam logic [WORD_W-1:0] MAX_WORD = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             dzero;
    logic             neg_re;
    logic             neg_im;
    logic [MAG_W-1:0] mag_re;
    logic [MAG_W-1:0] mag_im;
  } side_t;

  function automatic logic [WORD_W-1:0] abs_word(input logic [WORD_W-1:0] x);
    return x[WORD_W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic signed [MAG_W:0] to_signed(input logic neg,
                                                      input logic [MAG_W-1:0] p);
    return neg ? -$signed({1'b0, p}) : $signed({1'b0, p});
  endfunction

  // {sat, word}
  function automatic logic [WORD_W:0] clamp_word(input logic neg,
                                                 input logic [MAG_W-1:0] mag,
                                                 input logic big);
    logic [WORD_W:0] r;
    if (neg) begin
      if (big || mag > NEG_LIM) r = {1'b1, MIN_WORD};
      else                      r = {1'b0, WORD_W'(~mag + 1'b1)};
    end else begin
      if (big || mag > POS_LIM) r = {1'b1, MAX_WORD};
      else                      r = {1'b0, mag[WORD_W-1:0]};
    end
    return r;
  endfunction

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---- stage 1: operand magnitudes and signs, add sums ----
  logic                     v1;
  logic [1:0]               cmd1;
  logic [WORD_W-1:0]        m_ar1, m_ai1, m_br1, m_bi1;
  logic                     n_ar1, n_ai1, n_br1, n_bi1;
  logic signed [WORD_W:0]   add_re1, add_im1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    cmd1    <= operands.command;
    m_ar1   <= abs_word(operands.a_re);
    m_ai1   <= abs_word(operands.a_im);
    m_br1   <= abs_word(operands.b_re);
    m_bi1   <= abs_word(operands.b_im);
    n_ar1   <= operands.a_re[WORD_W-1];
    n_ai1   <= operands.a_im[WORD_W-1];
    n_br1   <= operands.b_re[WORD_W-1];
    n_bi1   <= operands.b_im[WORD_W-1];
    add_re1 <= (WORD_W+1)'(operands.a_re) + (WORD_W+1)'(operands.b_re);
    add_im1 <= (WORD_W+1)'(operands.a_im) + (WORD_W+1)'(operands.b_im);
  end

  // ---- stage 2: six 32x32 unsigned products ----
  // the squares feed |b|^2 for divide or |a|^2 for magnitude
  logic                   v2;
  logic [1:0]             cmd2;
  logic [MAG_W-1:0]       p_rr2, p_ii2, p_ri2, p_ir2, sq_x2, sq_y2;
  logic                   n_rr2, n_ii2, n_ri2, n_ir2;
  logic signed [WORD_W:0] add_re2, add_im2;
  logic [WORD_W-1:0]      op_x, op_y;

  assign op_x = (cmd1 == CMD_MAG) ? m_ar1 : m_br1;
  assign op_y = (cmd1 == CMD_MAG) ? m_ai1 : m_bi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    cmd2    <= cmd1;
    p_rr2   <= MAG_W'(m_ar1) * MAG_W'(m_br1);
    p_ii2   <= MAG_W'(m_ai1) * MAG_W'(m_bi1);
    p_ri2   <= MAG_W'(m_ar1) * MAG_W'(m_bi1);
    p_ir2   <= MAG_W'(m_ai1) * MAG_W'(m_br1);
    sq_x2   <= MAG_W'(op_x) * MAG_W'(op_x);
    sq_y2   <= MAG_W'(op_y) * MAG_W'(op_y);
    n_rr2   <= n_ar1 ^ n_br1;
    n_ii2   <= n_ai1 ^ n_bi1;
    n_ri2   <= n_ar1 ^ n_bi1;
    n_ir2   <= n_ai1 ^ n_br1;
    add_re2 <= add_re1;
    add_im2 <= add_im1;
  end

  // ---- stage 3: exact signed sums ----
  logic                    v3;
  logic [1:0]              cmd3;
  logic signed [MAG_W:0]   t_re3, t_im3;
  logic [MAG_W-1:0]        sumsq3;
  logic signed [MAG_W:0]   s_rr, s_ii, s_ri, s_ir, t_re, t_im;

  always_comb begin
    s_rr = to_signed(n_rr2, p_rr2);
    s_ii = to_signed(n_ii2, p_ii2);
    s_ri = to_signed(n_ri2, p_ri2);
    s_ir = to_signed(n_ir2, p_ir2);
    case (cmd2)
      CMD_ADD: begin
        t_re = (MAG_W+1)'(add_re2);
        t_im = (MAG_W+1)'(add_im2);
      end
      CMD_MUL: begin
        t_re = s_rr - s_ii;
        t_im = s_ri + s_ir;
      end
      CMD_DIV: begin
        // a times conj(b)
        t_re = s_rr + s_ii;
        t_im = s_ir - s_ri;
      end
      default: begin
        t_re = '0;
        t_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    cmd3   <= cmd2;
    t_re3  <= t_re;
    t_im3  <= t_im;
    sumsq3 <= sq_x2 + sq_y2;
  end

  // ---- stage 4: sign / magnitude split ----
  logic             v4;
  logic [1:0]       cmd4;
  logic             neg_re4, neg_im4;
  logic [MAG_W-1:0] mag_re4, mag_im4, sumsq4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    cmd4    <= cmd3;
    neg_re4 <= t_re3[MAG_W];
    neg_im4 <= t_im3[MAG_W];
    mag_re4 <= t_re3[MAG_W] ? MAG_W'(-t_re3) : t_re3[MAG_W-1:0];
    mag_im4 <= t_im3[MAG_W] ? MAG_W'(-t_im3) : t_im3[MAG_W-1:0];
    sumsq4  <= sumsq3;
  end

  // ---- divider and square root, side info delayed alongside ----
  logic [QUO_W-1:0]  quo_re, quo_im;
  logic              big_re, big_im;
  logic [WORD_W-1:0] root, root_p, root_d;
  side_t             side   [0:DIV_LAT-1];
  logic              side_v [0:DIV_LAT-1];

  cau_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .num_re (mag_re4),
    .num_im (mag_im4),
    .den    (sumsq4),
    .quo_re (quo_re),
    .quo_im (quo_im),
    .big_re (big_re),
    .big_im (big_im)
  );

  cau_sqrt u_sqrt (
    .clk      (clk),
    .radicand (sumsq4),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    // sqrt pipe is two ranks shorter than the divider
    root_p <= root;
    root_d <= root_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        side_v[k] <= 1'b0;
      end
    end else begin
      side_v[0] <= v4;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_v[k] <= side_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side[0].cmd    <= cmd4;
    side[0].dzero  <= (sumsq4 == '0);
    side[0].neg_re <= neg_re4;
    side[0].neg_im <= neg_im4;
    side[0].mag_re <= mag_re4;
    side[0].mag_im <= mag_im4;
    for (int k = 1; k < DIV_LAT; k++) begin
      side[k].cmd    <= side[k-1].cmd;
      side[k].dzero  <= side[k-1].dzero;
      side[k].neg_re <= side[k-1].neg_re;
      side[k].neg_im <= side[k-1].neg_im;
      side[k].mag_re <= side[k-1].mag_re;
      side[k].mag_im <= side[k-1].mag_im;
    end
  end

  // ---- select stage: per command sign, magnitude and overflow hint ----
  side_t            sd;
  logic             f_v, f_dz;
  logic             f_neg_re, f_neg_im, f_big_re, f_big_im;
  logic [MAG_W-1:0] f_mag_re, f_mag_im;
  logic             sel_neg_re, sel_neg_im, sel_big_re, sel_big_im, sel_dz;
  logic [MAG_W-1:0] sel_mag_re, sel_mag_im;

  assign sd = side[DIV_LAT-1];

  always_comb begin
    sel_neg_re = sd.neg_re;
    sel_neg_im = sd.neg_im;
    sel_mag_re = sd.mag_re;
    sel_mag_im = sd.mag_im;
    sel_big_re = 1'b0;
    sel_big_im = 1'b0;
    sel_dz     = 1'b0;
    case (sd.cmd)
      CMD_ADD: begin
      end
      CMD_MUL: begin
        sel_mag_re = sd.mag_re >> FRAC_BITS;
        sel_mag_im = sd.mag_im >> FRAC_BITS;
      end
      CMD_DIV: begin
        // a zero quotient stays positive
        sel_neg_re = sd.neg_re && (quo_re != '0);
        sel_neg_im = sd.neg_im && (quo_im != '0);
        sel_mag_re = MAG_W'(quo_re);
        sel_mag_im = MAG_W'(quo_im);
        sel_big_re = big_re;
        sel_big_im = big_im;
        sel_dz     = sd.dzero;
      end
      default: begin
        sel_neg_re = 1'b0;
        sel_neg_im = 1'b0;
        sel_mag_re = MAG_W'(root_d);
        sel_mag_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else begin
      f_v <= side_v[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    f_dz     <= sel_dz;
    f_neg_re <= sel_neg_re;
    f_neg_im <= sel_neg_im;
    f_mag_re <= sel_mag_re;
    f_mag_im <= sel_mag_im;
    f_big_re <= sel_big_re;
    f_big_im <= sel_big_im;
  end

  // ---- output register: saturation and status ----
  logic [WORD_W:0] cl_re, cl_im;

  assign cl_re = clamp_word(f_neg_re, f_mag_re, f_big_re);
  assign cl_im = clamp_word(f_neg_im, f_mag_im, f_big_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (f_dz) begin
      result.res_re <= '0;
      result.res_im <= '0;
      result.status <= ST_DIV0;
    end else begin
      result.res_re <= cl_re[WORD_W-1:0];
      result.res_im <= cl_im[WORD_W-1:0];
      result.status <= (cl_re[WORD_W] || cl_im[WORD_W]) ? ST_SAT : ST_OK;
    end
  end

  // ---- assertions ----
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted beat did not produce a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |-> ##LATENCY !done)
    else $error("result strobe without an accepted beat");

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_DIV0) |-> (result.res_re == '0 && result.res_im == '0))
    else $error("divide by zero with nonzero result");

endmodule

`default_nettype wire

// ===== rtl/cau_div.sv =====
// ============================================================================
// cau_div
// Two-lane pipelined restoring divider: (num << FRAC_BITS) / den, one
// quotient bit per stage, plus an overflow flag for quotients >= 2^33.
// ============================================================================
`default_nettype none

module cau_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic [cau_pkg::MAG_W-1:0]    num_re,
  input  logic [cau_pkg::MAG_W-1:0]    num_im,
  input  logic [cau_pkg::MAG_W-1:0]    den,
  output logic [cau_pkg::QUO_W-1:0]    quo_re,
  output logic [cau_pkg::QUO_W-1:0]    quo_im,
  output logic                         big_re,
  output logic                         big_im
);
  import cau_pkg::*;

  localparam int unsigned REM_W  = MAG_W + 1;
  localparam int unsigned PRE_SH = QUO_W - FRAC_BITS;

  logic [MAG_W-1:0] num_in   [0:1];
  logic [MAG_W-1:0] den_pipe [0:QUO_W];
  logic [MAG_W-1:0] rem      [0:1][0:QUO_W];
  logic [QUO_W-1:0] low      [0:1][0:QUO_W];
  logic [QUO_W-1:0] quo      [0:1][0:QUO_W];
  logic             big      [0:1][0:QUO_W];

  assign num_in[0] = num_re;
  assign num_in[1] = num_im;

  always_ff @(posedge clk) begin
    den_pipe[0] <= den;
    for (int s = 1; s <= QUO_W; s++) begin
      den_pipe[s] <= den_pipe[s-1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    // entry: top quotient bits checked at once, remainder preloaded
    always_ff @(posedge clk) begin
      rem[l][0] <= num_in[l] >> PRE_SH;
      low[l][0] <= QUO_W'(num_in[l] << FRAC_BITS);
      quo[l][0] <= '0;
      big[l][0] <= (num_in[l] >> PRE_SH) >= den;
    end

    for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
      logic [REM_W-1:0] trial;
      logic             ge;

      assign trial = {rem[l][s-1], low[l][s-1][QUO_W-1]};
      assign ge    = trial >= {1'b0, den_pipe[s-1]};

      always_ff @(posedge clk) begin
        rem[l][s] <= ge ? MAG_W'(trial - {1'b0, den_pipe[s-1]}) : trial[MAG_W-1:0];
        low[l][s] <= low[l][s-1] << 1;
        quo[l][s] <= {quo[l][s-1][QUO_W-2:0], ge};
        big[l][s] <= big[l][s-1];
      end
    end
  end

  assign quo_re = quo[0][QUO_W];
  assign quo_im = quo[1][QUO_W];
  assign big_re = big[0][QUO_W];
  assign big_im = big[1][QUO_W];

endmodule

`default_nettype wire

// ===== rtl/cau_sqrt.sv =====
// ============================================================================
// cau_sqrt
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// ============================================================================
`default_nettype none

module cau_sqrt (
  input  logic                       clk,
  input  logic [cau_pkg::MAG_W-1:0]  radicand,
  output logic [cau_pkg::WORD_W-1:0] root
);
  import cau_pkg::*;

  localparam int unsigned STEPS = MAG_W / 2;

  logic [MAG_W-1:0] rad [0:STEPS];
  logic [MAG_W-1:0] acc [0:STEPS];

  assign rad[0] = radicand;
  assign acc[0] = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [MAG_W-1:0] ONE_BIT = MAG_W'(1) << (MAG_W - 2 - 2 * k);
    logic [MAG_W-1:0] cand;
    logic             ge;

    assign cand = acc[k] + ONE_BIT;
    assign ge   = rad[k] >= cand;

    always_ff @(posedge clk) begin
      rad[k+1] <= ge ? rad[k] - cand : rad[k];
      acc[k+1] <= ge ? (acc[k] >> 1) + ONE_BIT : acc[k] >> 1;
    end
  end

  assign root = acc[STEPS][WORD_W-1:0];

endmodule

`default_nettype wire
